### rtl/core/srp_pkg.sv
`timescale 1ns / 1ps
// shared types and fixed-point constants of the range-reduced sine
package srp_pkg;

  // working format: signed, 40 fraction bits
  localparam int QF  = 40;
  localparam int QW  = 44;
  // width of the pi constant in that format
  localparam int PIW = 42;

  typedef logic signed [QW-1:0] q40_t;

  // high part of pi, exact: 3217/1024
  localparam logic [11:0]    C1_MANT = 12'd3217;
  localparam logic [PIW-1:0] C1_Q40  = 42'd3217 << 30;
  // magnitude of the low part of pi, with 40 and with 56 fraction bits
  localparam logic [PIW-1:0] C2_Q40  = 42'd9795450;
  localparam logic [39:0]    C2_Q56  = 40'd641954634999;
  localparam logic [PIW-1:0] PI_Q40  = C1_Q40 - C2_Q40;
  localparam logic [PIW-1:0] HALF_PI = PI_Q40 >> 1;

  // odd polynomial coefficients r1..r8, rounded to 40 fraction bits
  localparam q40_t COEF [0:7] = '{
    -44'sd183251937963,
     44'sd9162596898,
    -44'sd218157069,
     44'sd3029959,
    -44'sd27545,
     44'sd177,
    -44'sd1,
     44'sd0
  };

  // reduced argument and final sign, handed from front to back
  typedef struct packed {
    logic neg;
    q40_t f;
  } mid_beat_t;

  // queue depths, powers of two
  localparam int MID_DEPTH = 32;
  localparam int OUT_DEPTH = 32;

endpackage

### rtl/core/srp_fifo.sv
`timescale 1ns / 1ps
// small first-word-fall-through queue
module srp_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      cnt;

  assign empty   = (cnt == '0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) begin
        wp <= wp + AW'(1);
      end
      if (rd_en) begin
        rp <= rp + AW'(1);
      end
      cnt <= cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

### rtl/core/srp_mul.sv
`timescale 1ns / 1ps
// two-stage signed multiply, floored to 40 fraction bits, plus addend
module srp_mul (
  input  logic          clk,
  input  srp_pkg::q40_t a,
  input  srp_pkg::q40_t b,
  input  srp_pkg::q40_t c,
  output srp_pkg::q40_t p
);

  localparam int HW = 22;
  localparam int SW = 2 * srp_pkg::QW;

  logic signed [srp_pkg::QW+HW-1:0] ph;
  logic signed [srp_pkg::QW+HW:0]   pl;
  srp_pkg::q40_t                    c1;
  logic signed [SW-1:0]             sum;

  // partial products on the two halves of b
  always_ff @(posedge clk) begin
    ph <= a * $signed(b[srp_pkg::QW-1:HW]);
    pl <= a * $signed({1'b0, b[HW-1:0]});
    c1 <= c;
  end

  // addend folded in above the binary point keeps the floor exact
  assign sum = (SW'(ph) <<< HW) + SW'(pl) + (SW'(c1) <<< srp_pkg::QF);

  always_ff @(posedge clk) begin
    p <= srp_pkg::QW'(sum >>> srp_pkg::QF);
  end

endmodule

### rtl/core/srp_front.sv
`timescale 1ns / 1ps
// front end: magnitude, quotient by pi and reduced argument
module srp_front #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] angle,
  input  logic               mid_take,
  output logic               full,
  output logic               out_valid,
  output srp_pkg::mid_beat_t out_beat
);

  localparam int SH  = srp_pkg::QF - ANGLE_FRAC_BITS;
  localparam int YW  = 32 + SH;
  localparam int XW  = YW + 1;
  localparam longint unsigned MAX_Y = 64'd1 << (31 + SH);
  localparam longint unsigned MAX_N =
    (MAX_Y + 64'(srp_pkg::HALF_PI)) / 64'(srp_pkg::PI_Q40);
  localparam int NB  = $clog2(MAX_N + 1);
  // quotient estimate from the top bits times a reciprocal of pi
  localparam int DS  = 2;
  localparam int RS  = 28;
  localparam longint unsigned RM = (64'd1 << (RS + 32)) / 64'(srp_pkg::PI_Q40);
  localparam int RMW = $clog2(RM + 1);
  localparam int TW  = XW - 32;
  localparam int SW  = XW + 2;
  localparam int P1W = NB + 12;
  localparam int P2W = NB + 40;
  localparam int CW  = $clog2(srp_pkg::MID_DEPTH + 1);
  // the low part of pi adds at most one lsb per multiple of pi
  localparam srp_pkg::q40_t F_LIM = $signed(srp_pkg::QW'(srp_pkg::HALF_PI))
                                  + $signed(srp_pkg::QW'(MAX_N)) + 44'sd2;

  typedef struct packed {
    logic          neg;
    logic [YW-1:0] y;
    logic [XW-1:0] x;
    logic [NB-1:0] q;
  } dstage_t;

  logic [CW-1:0]   cnt;
  logic            accept;
  logic [31:0]     mag;
  logic [YW-1:0]   y_in;
  dstage_t         ds    [0:DS];
  dstage_t         dnext [0:DS-1];
  logic [DS:0]     dv;
  logic            pv;
  logic            pneg;
  logic            podd;
  logic [YW-1:0]   py;
  logic [P1W-1:0]  pp1;
  logic [P2W-1:0]  pp2;
  logic signed [SW-1:0] fw;
  logic            fv;
  srp_pkg::mid_beat_t fbeat;

  // credits cover the pipe and the queue behind it
  assign full   = (cnt == CW'(srp_pkg::MID_DEPTH));
  assign accept = in_valid & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CW'(accept) - CW'(mid_take);
    end
  end

  assign mag  = angle[31] ? (~$unsigned(angle) + 32'd1) : $unsigned(angle);
  assign y_in = YW'(mag) << SH;

  // estimate is exact or one low, a single compare puts it right
  always_comb begin
    logic [TW+RMW-1:0] prod;
    logic [XW-1:0]     pn;
    logic              ge;
    prod       = (TW+RMW)'(ds[0].x[XW-1:32]) * (TW+RMW)'(RM);
    dnext[0]   = ds[0];
    dnext[0].q = NB'(prod >> RS);
    pn         = XW'(ds[1].q) * XW'(srp_pkg::PI_Q40);
    ge         = ((ds[1].x - pn) >= XW'(srp_pkg::PI_Q40));
    dnext[1]   = ds[1];
    dnext[1].q = ds[1].q + NB'(ge);
  end

  always_ff @(posedge clk) begin
    ds[0].neg <= angle[31];
    ds[0].y   <= y_in;
    ds[0].x   <= XW'(y_in) + XW'(srp_pkg::HALF_PI);
    ds[0].q   <= '0;
    for (int d = 0; d < DS; d++) begin
      ds[d+1] <= dnext[d];
    end
    pneg  <= ds[DS].neg;
    podd  <= ds[DS].q[0];
    py    <= ds[DS].y;
    pp1   <= P1W'(ds[DS].q) * P1W'(srp_pkg::C1_MANT);
    pp2   <= P2W'(ds[DS].q) * P2W'(srp_pkg::C2_Q56);
    fbeat.neg <= pneg ^ podd;
    fbeat.f   <= fw[srp_pkg::QW-1:0];
  end

  // f = y - n*c1 + floor(n*|c2|)
  assign fw = $signed(SW'(py)) - $signed(SW'({pp1, 30'd0})) + $signed(SW'(pp2 >> 16));

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
      pv <= 1'b0;
      fv <= 1'b0;
    end else begin
      dv <= {dv[DS-1:0], accept};
      pv <= dv[DS];
      fv <= pv;
    end
  end

  assign out_valid = fv;
  assign out_beat  = fbeat;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(srp_pkg::MID_DEPTH))
    else $error("front credit count overrun");

  a_pipe_credit: assert property (@(posedge clk) disable iff (rst)
    CW'($countones({dv, pv, fv})) <= cnt)
    else $error("front pipe holds beats without credit");

  a_f_range: assert property (@(posedge clk) disable iff (rst)
    fv |-> (fbeat.f <= F_LIM) && (fbeat.f >= -F_LIM))
    else $error("reduced argument outside half pi");

endmodule

### rtl/core/srp_back.sv
`timescale 1ns / 1ps
// back end: odd polynomial, sign, scaling and saturation
module srp_back #(
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               mid_empty,
  input  srp_pkg::mid_beat_t mid_beat,
  output logic               mid_take,
  input  logic               res_pop,
  output logic               res_valid,
  output logic signed [31:0] res_sine
);

  localparam int NM  = 10;
  localparam int LAT = 2 * NM;
  localparam int CW  = $clog2(srp_pkg::OUT_DEPTH + 1);
  localparam srp_pkg::q40_t ONE = 44'sd1 <<< OUT_FRAC_BITS;

  typedef struct packed {
    logic          neg;
    srp_pkg::q40_t f;
    srp_pkg::q40_t g;
  } side_t;

  logic [CW-1:0] cnt;
  side_t         side [0:LAT];
  logic [LAT:0]  v;
  srp_pkg::q40_t mul_a   [0:NM-1];
  srp_pkg::q40_t mul_b   [0:NM-1];
  srp_pkg::q40_t mul_c   [0:NM-1];
  srp_pkg::q40_t mul_out [0:NM-1];
  srp_pkg::q40_t rs;
  srp_pkg::q40_t sh;
  srp_pkg::q40_t sat;

  assign mid_take = ~mid_empty & (cnt != CW'(srp_pkg::OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      v         <= '0;
      res_valid <= 1'b0;
    end else begin
      cnt       <= cnt + CW'(mid_take) - CW'(res_pop);
      v         <= {v[LAT-1:0], mid_take};
      res_valid <= v[LAT];
    end
  end

  always_ff @(posedge clk) begin
    side[0].neg <= mid_beat.neg;
    side[0].f   <= mid_beat.f;
    side[0].g   <= '0;
    for (int s = 1; s <= LAT; s++) begin
      if (s == 3) begin
        side[s].neg <= side[s-1].neg;
        side[s].f   <= side[s-1].f;
        side[s].g   <= mul_out[0];
      end else begin
        side[s] <= side[s-1];
      end
    end
    res_sine  <= 32'(sat);
  end

  // g = f*f, horner over g from r8 down to r1, then f + f*R(g)
  always_comb begin
    mul_a[0] = side[0].f;
    mul_b[0] = side[0].f;
    mul_c[0] = '0;
    mul_a[1] = srp_pkg::COEF[7];
    mul_b[1] = mul_out[0];
    mul_c[1] = srp_pkg::COEF[6];
    for (int k = 2; k < 8; k++) begin
      mul_a[k] = mul_out[k-1];
      mul_b[k] = side[2*k].g;
      mul_c[k] = srp_pkg::COEF[7-k];
    end
    mul_a[8] = mul_out[7];
    mul_b[8] = side[16].g;
    mul_c[8] = '0;
    mul_a[9] = side[18].f;
    mul_b[9] = mul_out[8];
    mul_c[9] = side[18].f;
  end

  for (genvar k = 0; k < NM; k++) begin : g_mul
    srp_mul u_mul (
      .clk (clk),
      .a   (mul_a[k]),
      .b   (mul_b[k]),
      .c   (mul_c[k]),
      .p   (mul_out[k])
    );
  end

  always_comb begin
    rs = side[LAT].neg ? -mul_out[NM-1] : mul_out[NM-1];
    sh = rs >>> (srp_pkg::QF - OUT_FRAC_BITS);
    if (sh > ONE) begin
      sat = ONE;
    end else if (sh < -ONE) begin
      sat = -ONE;
    end else begin
      sat = sh;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(srp_pkg::OUT_DEPTH))
    else $error("back credit count overrun");

  a_pipe_credit: assert property (@(posedge clk) disable iff (rst)
    CW'($countones({v, res_valid})) <= cnt)
    else $error("back pipe holds beats without credit");

  a_g_sign: assert property (@(posedge clk) disable iff (rst)
    v[2] |-> (mul_out[0] >= 0))
    else $error("square of reduced argument negative");

endmodule

### rtl/core/sine_range_reduced_poly.sv
`timescale 1ns / 1ps
// top level of the range-reduced polynomial sine
//
// input channel: push/full, one angle beat (radians, signed, ANGLE_FRAC_BITS
//   fraction bits) taken at each edge with push high and full low
// result channel: empty/pop, the oldest sine (signed, OUT_FRAC_BITS fraction
//   bits, clamped to plus or minus one) sits on sine while empty is low and
//   leaves at each edge with pop high and empty low
// one beat in, one beat out, in order; no state between beats
// throughput: one beat per cycle while pop keeps up
// from accept to sine showing, a beat passes the five-stage
//   front (quotient by pi from a reciprocal multiply and one correction),
//   the two queues and the ten two-stage multiplies
// the front and back each run on credits against a 32-deep queue; a stalled
//   receiver fills the result queue, the back stops pulling, the middle queue
//   fills, then full rises; nothing is dropped
// reset (rst, synchronous) empties both queues and all valid bits at once
module sine_range_reduced_poly #(
  parameter int ANGLE_FRAC_BITS = 24,
  parameter int OUT_FRAC_BITS   = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] angle,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] sine
);

  localparam int MW = $bits(srp_pkg::mid_beat_t);

  // front to middle queue
  logic               f_valid;
  srp_pkg::mid_beat_t f_beat;
  // middle queue to back
  logic               mid_empty;
  logic               mid_take;
  logic [MW-1:0]      mid_rd;
  // back to result queue
  logic               res_valid;
  logic signed [31:0] res_sine;
  logic               res_pop;
  logic [31:0]        out_rd;

  srp_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .angle     (angle),
    .mid_take  (mid_take),
    .full      (full),
    .out_valid (f_valid),
    .out_beat  (f_beat)
  );

  // reduced argument waits here until the polynomial side has credit
  srp_fifo #(
    .WIDTH (MW),
    .DEPTH (srp_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_valid),
    .wr_data (f_beat),
    .rd_en   (mid_take),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  srp_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_beat  (srp_pkg::mid_beat_t'(mid_rd)),
    .mid_take  (mid_take),
    .res_pop   (res_pop),
    .res_valid (res_valid),
    .res_sine  (res_sine)
  );

  // result queue decouples the receiver from the polynomial pipe
  assign res_pop = pop & ~empty;

  srp_fifo #(
    .WIDTH (32),
    .DEPTH (srp_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data ($unsigned(res_sine)),
    .rd_en   (res_pop),
    .rd_data (out_rd),
    .empty   (empty)
  );

  assign sine = $signed(out_rd);

endmodule

### dv/tb_sine_range_reduced_poly.sv
`timescale 1ns / 1ps
// self-checking testbench of the range-reduced polynomial sine
module tb_sine_range_reduced_poly;

  localparam int ANGLE_FRAC_BITS = 24;
  localparam int OUT_FRAC_BITS   = 30;
  localparam int RAND_ANGLES     = 1800;
  localparam int IDLE_LIMIT      = 5000;
  localparam int HOLD_CYCLES     = 400;

  // wide signed scratch type, roomy enough for every exact product
  typedef logic signed [127:0] wide_t;

  // pi split into an exact high part and a small low part
  localparam wide_t PI_HI      = wide_t'(3217) <<< 30;
  localparam wide_t PI_LO_Q40  = 128'sd9795450;
  localparam wide_t PI_LO_Q56  = 128'sd641954634999;
  localparam wide_t PI_Q       = PI_HI - PI_LO_Q40;
  // odd polynomial coefficients r1..r8 with 40 fraction bits
  localparam wide_t POLY_COEF [8] = '{
    -128'sd183251937963, 128'sd9162596898, -128'sd218157069, 128'sd3029959,
    -128'sd27545, 128'sd177, -128'sd1, 128'sd0
  };

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               push  = 1'b0;
  logic               full;
  logic signed [31:0] angle = '0;
  logic               empty;
  logic               pop   = 1'b0;
  logic signed [31:0] sine;

  sine_range_reduced_poly #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .OUT_FRAC_BITS  (OUT_FRAC_BITS)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .angle(angle),
    .empty(empty),
    .pop  (pop),
    .sine (sine)
  );

  always #5 clk = ~clk;

  logic signed [31:0] angle_q [$];  // angles waiting to be offered
  logic signed [31:0] sine_q  [$];  // predicted sines, oldest first
  int                 n_sent     = 0;
  int                 n_got      = 0;
  int                 n_err      = 0;
  int                 idle_cnt   = 0;
  bit                 stim_done  = 1'b0;

  // exact product of two 40-fraction-bit values, floored back to 40 bits
  function automatic wide_t mul_q40(input wide_t a, input wide_t b);
    return (a * b) >>> 40;
  endfunction

  // predicted sine of one angle
  function automatic logic signed [31:0] sine_of(input logic signed [31:0] ang);
    wide_t mag, y, n, f, g, acc, r;
    wide_t one;
    int    i;
    one = wide_t'(1) <<< OUT_FRAC_BITS;
    // magnitude is exact, even for the most negative angle
    mag = ang[31] ? -wide_t'(ang) : wide_t'(ang);
    y   = mag <<< (40 - ANGLE_FRAC_BITS);
    // nearest multiple of pi, halves rounded up
    n   = (y + PI_Q / 2) / PI_Q;
    f   = y - n * PI_HI + ((n * PI_LO_Q56) >>> 16);
    g   = mul_q40(f, f);
    acc = POLY_COEF[7];
    for (i = 6; i >= 0; i--) acc = mul_q40(acc, g) + POLY_COEF[i];
    acc = mul_q40(acc, g);
    r   = f + mul_q40(f, acc);
    // negative angle and odd multiple each flip the sign
    if (ang[31] ^ n[0]) r = -r;
    r = r >>> (40 - OUT_FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[31:0];
  endfunction

  // sender: bursts and gaps, plus one pause until the block has drained
  int burst_left = 0;
  int gap_left   = 0;
  bit drained    = 1'b0;

  always @(posedge clk) begin
    bit go;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        sine_q.push_back(sine_of(angle));
        void'(angle_q.pop_front());
        n_sent++;
      end
      go = 1'b0;
      if (n_sent >= 900 && !drained) begin
        // hold the input until every outstanding beat has come back
        if (sine_q.size() == 0) drained = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (angle_q.size() > 0) begin
        go = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else if (n_sent > 200 && n_sent < 400) begin
          // stretch with no gaps at all
          burst_left = 0;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = $urandom_range(0, 6);
        end
      end
      push <= go;
      if (go) angle <= angle_q[0];
    end
  end

  // receiver: own stall pattern, with one long hold-off to back up the block
  int  hold_left = 0;
  bit  held      = 1'b0;

  always @(posedge clk) begin
    logic signed [31:0] want;
    bit                 take;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_got++;
        if (sine_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected sine beat 0x%08h", $time, sine);
        end else begin
          want = sine_q.pop_front();
          if (sine !== want) begin
            n_err++;
            $display("%0t: sine mismatch: expected 0x%08h actual 0x%08h",
                     $time, want, sine);
          end
        end
      end
      if (!held && n_got >= 400) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (((n_got / 150) % 3) == 0) begin
        take = 1'b1;
      end else begin
        take = ($urandom_range(0, 3) != 0);
      end
      pop <= take;
    end
  end

  // watchdog: too long without any accepted beat on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cnt <= 0;
    end else if (!stim_done) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d beats still expected", $time, sine_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int pick;
    // directed: extremes, small angles, points around multiples of pi
    angle_q.push_back(32'sd0);
    angle_q.push_back(32'sd1);
    angle_q.push_back(-32'sd1);
    angle_q.push_back(32'sh7fffffff);
    angle_q.push_back(32'sh80000000);
    angle_q.push_back(32'sh80000001);
    angle_q.push_back(32'sd26353589);   // near pi/2, sine near one
    angle_q.push_back(-32'sd26353589);
    angle_q.push_back(32'sd26353590);
    angle_q.push_back(32'sd52707179);   // near pi
    angle_q.push_back(-32'sd52707179);
    angle_q.push_back(32'sd79060768);   // near 3pi/2, rounding boundary
    angle_q.push_back(32'sd79060769);
    angle_q.push_back(-32'sd79060768);
    angle_q.push_back(32'sd105414357);  // near 2pi
    angle_q.push_back(32'sd1024);       // tiny reduced argument
    angle_q.push_back(-32'sd1024);
    angle_q.push_back(32'sd52707180);
    angle_q.push_back(32'sd2108287180); // near a large multiple of pi
    angle_q.push_back(-32'sd2108287180);
    // random: full range, a few turns, and small angles
    for (k = 0; k < RAND_ANGLES; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        angle_q.push_back($urandom);
      else if (pick < 8)
        angle_q.push_back($signed($urandom_range(0, 843314864)) - 32'sd421657432);
      else
        angle_q.push_back($signed($urandom_range(0, 131072)) - 32'sd65536);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (angle_q.size() == 0 && sine_q.size() == 0);
    stim_done = 1'b1;
    repeat (60) @(posedge clk);
    $display("covered %0d angles (directed extremes, pi boundaries, random range)",
             n_sent);
    $display("%0d sines checked under bursty input, stalls and a full back-up", n_got);
    if (n_err == 0 && sine_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
